// ----- hw/rtl/sspf_pkg.sv -----
package sspf_pkg;

  // Q9.30 state word and multiplier operand / product types
  typedef logic signed [39:0] word_t;
  typedef logic signed [43:0] mul_a_t;
  typedef logic signed [41:0] mul_b_t;
  typedef logic signed [43:0] mul_p_t;

  // Per-lane handshake status toward the merge stage
  typedef struct packed {
    logic busy;
    logic done;
  } lane_sts_t;

  // Configuration register indexes
  typedef enum logic {
    REG_AMOUNT = 1'b0,
    REG_MIX    = 1'b1
  } cfg_reg_t;

  localparam logic [16:0] AMOUNT_RESET = 17'd32768;
  localparam logic [16:0] MIX_RESET    = 17'd65536;
  localparam logic [16:0] PARAM_MAX    = 17'd65536;

  // Q30 constants
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
  localparam logic signed [31:0] C_0777  = 32'sd834297397;
  localparam logic signed [31:0] C_068   = 32'sd730144440;
  localparam logic signed [31:0] C_0157  = 32'sd168577466;

  // 40-bit saturation limits, held at 48 bits
  localparam logic signed [47:0] SAT_HI = 48'sh00_7F_FFFF_FFFF;
  localparam logic signed [47:0] SAT_LO = -48'sh00_80_0000_0000;

endpackage

// ----- hw/rtl/sspf_mul.sv -----
module sspf_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  sspf_pkg::mul_a_t  a,
  input  sspf_pkg::mul_b_t  b,
  output logic              done,
  output sspf_pkg::mul_p_t  p
);

  typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_RND} mst_t;

  mst_t                st_r;
  logic                done_r;
  logic                neg_r;
  logic [41:0]         ua_r;
  logic [31:0]         ub_r;
  logic [52:0]         plo_r;
  logic [52:0]         phi_r;
  sspf_pkg::mul_p_t    p_r;

  logic [43:0]         abs_a;
  logic [41:0]         abs_b;
  logic [41:0]         ua_nxt;
  logic [31:0]         ub_nxt;
  logic [73:0]         full;
  logic [73:0]         rnd;
  logic [43:0]         mag;

  // Magnitudes, clamped to 2^41 and 2^31
  always_comb begin
    abs_a  = a[43] ? 44'(-a) : 44'(a);
    abs_b  = b[41] ? 42'(-b) : 42'(b);
    ua_nxt = (abs_a > (44'd1 << 41)) ? {1'b1, 41'd0} : abs_a[41:0];
    ub_nxt = (abs_b > (42'd1 << 31)) ? 32'h8000_0000 : abs_b[31:0];
  end

  // Join partial products, round half away from zero
  always_comb begin
    full = ({21'd0, phi_r} << 21) + {21'd0, plo_r};
    rnd  = full + (74'd1 << 29);
    mag  = rnd[73:30];
  end

  // Sequence: latch, low partial, high partial, round
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= M_IDLE;
      done_r <= 1'b0;
    end else begin
      unique case (st_r)
        M_IDLE: begin
          done_r <= 1'b0;
          if (start) begin
            neg_r <= a[43] ^ b[41];
            ua_r  <= ua_nxt;
            ub_r  <= ub_nxt;
            st_r  <= M_LO;
          end
        end
        M_LO: begin
          plo_r <= ua_r[20:0] * ub_r;
          st_r  <= M_HI;
        end
        M_HI: begin
          phi_r <= ua_r[41:21] * ub_r;
          st_r  <= M_RND;
        end
        M_RND: begin
          p_r    <= neg_r ? -$signed(mag) : $signed(mag);
          done_r <= 1'b1;
          st_r   <= M_IDLE;
        end
        default: st_r <= M_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign p    = p_r;

`ifndef ASSERT_OFF
  a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(start, 4))
    else $error("product done without a start four cycles earlier");
`endif

endmodule

// ----- hw/rtl/sspf_lane.sv -----
module sspf_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                take,
  input  logic signed [23:0]  sample,
  input  logic [16:0]         amount,
  input  logic [16:0]         mix,
  output sspf_pkg::lane_sts_t sts,
  output logic signed [23:0]  res
);

  typedef enum logic [3:0] {
    S_IDLE, S_COEF, S_MUL, S_WAIT, S_SM1, S_SM2, S_SM3, S_SM4, S_DONE
  } st_t;

  typedef enum logic [3:0] {
    OP_ING, OP_T157, OP_W777, OP_DK, OP_INS, OP_INC, OP_TUNE,
    OP_FB1, OP_FB2, OP_V1, OP_V2
  } op_t;

  function automatic sspf_pkg::word_t sat40(input logic signed [47:0] v);
    if (v > sspf_pkg::SAT_HI) return sspf_pkg::SAT_HI[39:0];
    if (v < sspf_pkg::SAT_LO) return sspf_pkg::SAT_LO[39:0];
    return v[39:0];
  endfunction

  // Halve, truncating toward zero
  function automatic logic signed [47:0] half(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = v;
    if (v[47]) t = v + 48'sd1;
    return t >>> 1;
  endfunction

  st_t                 st_r;
  op_t                 op_r;
  logic signed [30:0]  xs_r;
  logic [16:0]         a_r;
  logic [16:0]         b_r;
  logic [30:0]         kal_r;
  logic [30:0]         onemk_r;
  logic signed [31:0]  wet_r;
  logic [30:0]         dry_r;
  logic signed [31:0]  tune_r;
  sspf_pkg::mul_p_t    ing_r, wet777_r, dk_r, ins_r, f1_r, v1_r;
  sspf_pkg::word_t     s1_r, s2_r, s3_r, sl1_r, sl2_r, sl3_r;
  sspf_pkg::word_t     d1_r, d2_r, d3_r, out_r, gain_r;
  logic signed [23:0]  res_r;

  logic                mul_start;
  sspf_pkg::mul_a_t    mul_a;
  sspf_pkg::mul_b_t    mul_b;
  logic                mul_done;
  sspf_pkg::mul_p_t    mul_p;

  logic [33:0]         aa;
  logic [33:0]         kdiff;
  logic [30:0]         kal_nxt;
  logic [31:0]         bs;
  logic [31:0]         drv;
  logic signed [44:0]  dd;
  logic [44:0]         dd_abs;
  sspf_pkg::word_t     inc, g1, halfk, gain_nxt;
  logic signed [44:0]  fb;
  sspf_pkg::word_t     fb_nxt;
  logic signed [45:0]  v;
  logic signed [45:0]  q;
  logic signed [23:0]  res_nxt;

  sspf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // Coefficients from the clamped register values
  always_comb begin
    aa      = a_r * a_r;
    kdiff   = 34'h1_0000_0000 - aa;
    kal_nxt = kdiff[32:2];
    bs      = {b_r[16:0], 15'd0};
    drv     = 32'h8000_0000 - bs;
  end

  // Select multiplier operands for the current step
  always_comb begin
    dd     = 45'(dk_r) - 45'(out_r);
    dd_abs = dd[44] ? 45'(-dd) : 45'(dd);
    mul_a  = '0;
    mul_b  = '0;
    unique case (op_r)
      OP_ING:  begin mul_a = $signed({13'd0, onemk_r}); mul_b = 42'(sspf_pkg::C_0777); end
      OP_T157: begin mul_a = $signed({13'd0, kal_r});   mul_b = 42'(sspf_pkg::C_0157); end
      OP_W777: begin mul_a = 44'(wet_r);                mul_b = 42'(sspf_pkg::C_0777); end
      OP_DK:   begin mul_a = 44'(xs_r);                 mul_b = ing_r[41:0];           end
      OP_INS:  begin mul_a = dk_r;                      mul_b = $signed({11'd0, onemk_r}); end
      OP_INC:  begin mul_a = $signed(dd_abs[43:0]);     mul_b = $signed({11'd0, kal_r}); end
      OP_TUNE: begin mul_a = dk_r;                      mul_b = 42'(tune_r);           end
      OP_FB1:  begin mul_a = 44'(out_r);                mul_b = 42'(gain_r);           end
      OP_FB2:  begin
        mul_a = dk_r;
        mul_b = 42'(sspf_pkg::ONE_Q30) - 42'(gain_r);
      end
      OP_V1:   begin mul_a = 44'(xs_r);                 mul_b = $signed({11'd0, dry_r}); end
      OP_V2:   begin mul_a = 44'(out_r);                mul_b = wet777_r[41:0];        end
      default: begin mul_a = '0;                        mul_b = '0;                    end
    endcase
  end

  // Write-back arithmetic on the finished product
  always_comb begin
    inc   = sat40(48'(mul_p) <<< 3);
    g1    = sat40(half(48'(gain_r) + 48'(inc)));
    halfk = $signed({10'd0, kal_r[30:1]});
    if (g1 > halfk) gain_nxt = halfk;
    else if (g1 < 40'sd0) gain_nxt = '0;
    else gain_nxt = g1;

    fb = 45'(f1_r) + 45'(mul_p);
    if (fb > 45'(sspf_pkg::ONE_Q30)) fb_nxt = 40'(sspf_pkg::ONE_Q30);
    else if (fb < -45'(sspf_pkg::ONE_Q30)) fb_nxt = -40'(sspf_pkg::ONE_Q30);
    else fb_nxt = fb[39:0];

    v = 46'(v1_r) + 46'(mul_p) + 46'sd64;
    q = v >>> 7;
    if (q > 46'sd8388607) res_nxt = 24'sh7F_FFFF;
    else if (q < -46'sd8388608) res_nxt = -24'sh80_0000;
    else res_nxt = q[23:0];
  end

  assign mul_start = (st_r == S_MUL);

  // Sequencer: coefficients, shared multiplier steps, smoothing chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      op_r   <= OP_ING;
      s1_r   <= '0; s2_r  <= '0; s3_r  <= '0;
      sl1_r  <= '0; sl2_r <= '0; sl3_r <= '0;
      d1_r   <= '0; d2_r  <= '0; d3_r  <= '0;
      out_r  <= '0; gain_r <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (start) begin
            xs_r <= {sample, 7'd0};
            a_r  <= (amount > sspf_pkg::PARAM_MAX) ? sspf_pkg::PARAM_MAX : amount;
            b_r  <= (mix > sspf_pkg::PARAM_MAX) ? sspf_pkg::PARAM_MAX : mix;
            st_r <= S_COEF;
          end
        end
        S_COEF: begin
          kal_r   <= kal_nxt;
          onemk_r <= 31'h4000_0000 - kal_nxt;
          wet_r   <= $signed(bs - 32'h4000_0000);
          dry_r   <= (drv > 32'h4000_0000) ? 31'h4000_0000 : drv[30:0];
          op_r    <= OP_ING;
          st_r    <= S_MUL;
        end
        S_MUL: st_r <= S_WAIT;
        S_WAIT: begin
          if (mul_done) begin
            st_r <= S_MUL;
            unique case (op_r)
              OP_ING:  begin ing_r <= mul_p; op_r <= OP_T157; end
              OP_T157: begin
                tune_r <= sspf_pkg::ONE_Q30 - sspf_pkg::C_068 - 32'(mul_p);
                op_r   <= OP_W777;
              end
              OP_W777: begin wet777_r <= mul_p; op_r <= OP_DK; end
              OP_DK:   begin dk_r <= mul_p; op_r <= OP_INS; end
              OP_INS:  begin ins_r <= mul_p; st_r <= S_SM1; end
              OP_INC:  begin gain_r <= gain_nxt; op_r <= OP_TUNE; end
              OP_TUNE: begin
                out_r <= sat40(48'(out_r) + 48'(mul_p));
                s3_r  <= s2_r;
                s2_r  <= s1_r;
                op_r  <= OP_FB1;
              end
              OP_FB1:  begin f1_r <= mul_p; op_r <= OP_FB2; end
              OP_FB2:  begin s1_r <= fb_nxt; op_r <= OP_V1; end
              OP_V1:   begin v1_r <= mul_p; op_r <= OP_V2; end
              OP_V2:   begin res_r <= res_nxt; st_r <= S_DONE; end
              default: st_r <= S_DONE;
            endcase
          end
        end
        S_SM1: begin
          sl3_r <= sat40(half(48'(sl3_r) + 48'(s3_r) - 48'(s2_r)));
          sl2_r <= sat40(half(48'(sl2_r) + 48'(s2_r) - 48'(s1_r)));
          sl1_r <= sat40(half(48'(sl1_r) + 48'(s1_r) - 48'(ins_r)));
          st_r  <= S_SM2;
        end
        S_SM2: begin
          d2_r <= sat40(half(48'(d2_r) + 48'(sl3_r) - 48'(sl2_r)));
          d1_r <= sat40(half(48'(d1_r) + 48'(sl2_r) - 48'(sl1_r)));
          st_r <= S_SM3;
        end
        S_SM3: begin
          d3_r <= sat40(half(48'(d3_r) + 48'(d2_r) - 48'(d1_r)));
          st_r <= S_SM4;
        end
        S_SM4: begin
          out_r <= sat40(half(48'(out_r) + 48'(s1_r) + 48'(sl2_r) + 48'(d3_r)));
          op_r  <= OP_INC;
          st_r  <= S_MUL;
        end
        S_DONE: begin
          if (take) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign sts.busy = (st_r != S_IDLE);
  assign sts.done = (st_r == S_DONE);
  assign res      = res_r;

`ifndef ASSERT_OFF
  a_gain_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    !gain_r[39])
    else $error("adaptive gain went negative");
`endif

endmodule

// ----- hw/rtl/stereo_slew_predictive_filter.sv -----
// Stereo slew-predictive filter.
// Input channel: in_valid / in_stall with one stereo frame per transaction
// (in_sample_left, in_sample_right, signed Q1.23). Output channel: out_valid /
// out_stall with out_left / out_right, signed Q1.23, one result per frame.
// Config: cfg_we writes cfg_data into amount (index 0) or mix (index 1).
// Each channel runs in its own lane with its own 21x32 multiplier,
// shared by the lane's steps, that forms each rounded Q30 product; a
// lane works through eleven products and a four-step smoothing chain to
// its done state, and the merge register takes the result once both
// lanes are done and the output register frees. A new frame is taken
// once both lanes are idle; serial multiplier use sets the frame rate.
// A finished result sits in the output register while the lanes take the
// next frame; if out_stall holds, the lanes wait in their done state and
// in_stall stays high until the output register frees.
// Reset (synchronous, rst_n low) clears all filter state to zero, sets
// amount to 32768 and mix to 65536, and empties the output register.
module stereo_slew_predictive_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_sample_left,
  input  logic signed [23:0] in_sample_right,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_left,
  output logic signed [23:0] out_right,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [16:0]        cfg_data
);

  logic [16:0]         amount_r;
  logic [16:0]         mix_r;
  logic                out_valid_r;
  logic signed [23:0]  out_left_r;
  logic signed [23:0]  out_right_r;

  sspf_pkg::lane_sts_t sts_left, sts_right;
  logic signed [23:0]  res_left, res_right;
  logic                in_acc;
  logic                merge;

  assign in_stall = sts_left.busy | sts_right.busy;
  assign in_acc   = in_valid & ~in_stall;
  assign merge    = sts_left.done & sts_right.done & (~out_valid_r | ~out_stall);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amount_r <= sspf_pkg::AMOUNT_RESET;
      mix_r    <= sspf_pkg::MIX_RESET;
    end else if (cfg_we) begin
      unique case (sspf_pkg::cfg_reg_t'(cfg_index))
        sspf_pkg::REG_AMOUNT: amount_r <= cfg_data;
        sspf_pkg::REG_MIX:    mix_r    <= cfg_data;
        default:              amount_r <= amount_r;
      endcase
    end
  end

  sspf_lane u_lane_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_acc),
    .take   (merge),
    .sample (in_sample_left),
    .amount (amount_r),
    .mix    (mix_r),
    .sts    (sts_left),
    .res    (res_left)
  );

  sspf_lane u_lane_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_acc),
    .take   (merge),
    .sample (in_sample_right),
    .amount (amount_r),
    .mix    (mix_r),
    .sts    (sts_right),
    .res    (res_right)
  );

  // Merge both lanes into the output register; drop valid when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (merge) begin
      out_valid_r <= 1'b1;
      out_left_r  <= res_left;
      out_right_r <= res_right;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;

`ifndef ASSERT_OFF
  a_lanes_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (sts_left.busy && sts_right.busy))
    else $error("accepted frame did not start both lanes");
  a_merge_valid: assert property (@(posedge clk) disable iff (!rst_n)
    merge |=> out_valid_r)
    else $error("merged result not presented");
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    sts_left.done == sts_right.done)
    else $error("lanes out of step");
`endif

endmodule
